/* rtl/hrfe_pkg.sv */
// hrfe_pkg: widths, constants and band limits for the rumble half-frame encoder
// no dependencies; imported by both RTL modules and both testbench files
`default_nettype none

package hrfe_pkg;

  // field widths
  localparam int FREQ_W = 16;
  localparam int AMP_W  = 17;
  localparam int BYTE_W = 8;
  localparam int FS_W   = 8;

  // fraction bits of the frequency inputs
  localparam int FREQ_FRAC_BITS = 4;

  // n = (f << (30 - FRAC)) / 10 is computed as (f/5 << K) + ((f%5) << K) / 5
  localparam int K_SHIFT = 29 - FREQ_FRAC_BITS;
  localparam int QUOT_W  = FREQ_W - 2;
  localparam int N_W     = QUOT_W + K_SHIFT;
  localparam int M_W     = 31;
  localparam int E_MAX   = N_W - M_W;
  localparam int E_W     = $clog2(E_MAX + 1);
  localparam int FRAC_W  = 6;
  localparam int CODE_W  = E_W + FRAC_W;

  // reciprocal of five for a 16-bit dividend: floor(x * 52429 / 2^18)
  localparam logic [FREQ_W-1:0] RECIP5       = 16'd52429;
  localparam int                RECIP5_SHIFT = 18;

  // ((r << K) / 5) for r = 1..4
  localparam logic [K_SHIFT-1:0] REM_TERM1 = K_SHIFT'((64'd1 << K_SHIFT) / 5);
  localparam logic [K_SHIFT-1:0] REM_TERM2 = K_SHIFT'((64'd2 << K_SHIFT) / 5);
  localparam logic [K_SHIFT-1:0] REM_TERM3 = K_SHIFT'((64'd3 << K_SHIFT) / 5);
  localparam logic [K_SHIFT-1:0] REM_TERM4 = K_SHIFT'((64'd4 << K_SHIFT) / 5);

  // pipeline depth of the frequency log unit (divide, normalize, six squarings)
  localparam int FREQ_LAT = 2 + FRAC_W;

  // band limits of the frequency codes
  localparam logic [CODE_W-1:0] HI_CODE_MIN = CODE_W'(97);
  localparam logic [CODE_W-1:0] HI_CODE_MAX = CODE_W'(223);
  localparam logic [CODE_W-1:0] LO_CODE_MIN = CODE_W'(65);
  localparam logic [CODE_W-1:0] LO_CODE_MAX = CODE_W'(191);
  localparam logic [CODE_W-1:0] HI_CODE_BASE = CODE_W'(8'h60);
  localparam logic [CODE_W-1:0] LO_CODE_BASE = CODE_W'(8'h40);

  // amplitude 1.0 and the reset full-scale code
  localparam logic [AMP_W-1:0] AMP_ONE      = 17'h10000;
  localparam logic [FS_W-1:0]  FS_RESET     = 8'hc8;

  // neutral half-frame
  localparam logic [BYTE_W-1:0] STOP_BYTE0 = 8'h00;
  localparam logic [BYTE_W-1:0] STOP_BYTE1 = 8'h04;
  localparam logic [BYTE_W-1:0] STOP_BYTE2 = 8'h81;
  localparam logic [BYTE_W-1:0] STOP_BYTE3 = 8'h40;

  // transaction kinds
  typedef enum logic {
    KIND_PLAY = 1'b0,
    KIND_STOP = 1'b1
  } kind_e;

endpackage

`default_nettype wire

/* rtl/hrfe_freq_log.sv */
// hrfe_freq_log: pipelined round(32*log2(f/10)) for one frequency input
// depends on hrfe_pkg; FREQ_LAT register stages, a new input every cycle
`default_nettype none

module hrfe_freq_log import hrfe_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic [FREQ_W-1:0] freq_i,
  output logic      [CODE_W-1:0] code_o
);

  // divide by five through the reciprocal
  logic [2*FREQ_W-1:0] recip_prod;
  logic [QUOT_W-1:0]   quot;
  logic [FREQ_W-1:0]   five_quot;
  logic [2:0]          rem;

  assign recip_prod = freq_i * RECIP5;
  assign quot       = recip_prod[RECIP5_SHIFT +: QUOT_W];
  assign five_quot  = {quot, 2'b00} + FREQ_W'(quot);
  assign rem        = 3'(freq_i - five_quot);

  logic [QUOT_W-1:0] quot_q;
  logic [2:0]        rem_q;

  always_ff @(posedge clk_i) begin
    quot_q <= quot;
    rem_q  <= rem;
  end

  // rebuild n = f * 2^(30-frac) / 10 in Q30
  logic [K_SHIFT-1:0] rem_term;
  logic [N_W-1:0]     n_val;

  always_comb begin
    case (rem_q)
      3'd1:    rem_term = REM_TERM1;
      3'd2:    rem_term = REM_TERM2;
      3'd3:    rem_term = REM_TERM3;
      3'd4:    rem_term = REM_TERM4;
      default: rem_term = '0;
    endcase
  end

  assign n_val = {quot_q, K_SHIFT'(0)} + N_W'(rem_term);

  // exponent from the top set bit at or above 2^30, then normalize
  logic [E_W-1:0] exp_d;
  logic           small_d;
  logic [N_W-1:0] n_shift;

  always_comb begin
    exp_d = '0;
    for (int i = 0; i <= E_MAX; i++) begin
      if (n_val[M_W-1+i]) begin
        exp_d = E_W'(i);
      end
    end
  end

  assign small_d = ~|n_val[N_W-1:M_W-1];
  assign n_shift = n_val >> exp_d;

  // per-stage registers; index 0 holds the normalized mantissa
  logic [M_W-1:0]    m_q     [FRAC_W+1];
  logic [E_W-1:0]    exp_q   [FRAC_W+1];
  logic              small_q [FRAC_W+1];
  logic [FRAC_W-1:0] frac_q  [FRAC_W+1];

  always_ff @(posedge clk_i) begin
    m_q[0]     <= n_shift[M_W-1:0];
    exp_q[0]   <= exp_d;
    small_q[0] <= small_d;
    frac_q[0]  <= '0;
  end

  // one fraction bit per stage by repeated squaring
  for (genvar k = 0; k < FRAC_W; k++) begin : g_sq
    logic [2*M_W-1:0] sq;
    logic [M_W:0]     sq_top;
    logic             bit_d;
    logic [M_W-1:0]   m_d;

    assign sq     = m_q[k] * m_q[k];
    assign sq_top = sq[M_W-1 +: M_W+1];
    assign bit_d  = sq_top[M_W];
    assign m_d    = bit_d ? sq_top[M_W:1] : sq_top[M_W-1:0];

    always_ff @(posedge clk_i) begin
      m_q[k+1]     <= m_d;
      exp_q[k+1]   <= exp_q[k];
      small_q[k+1] <= small_q[k];
      frac_q[k+1]  <= {frac_q[k][FRAC_W-2:0], bit_d};
    end
  end

  // round to the half step: (L + 1) >> 1, zero below 10 Hz
  logic [CODE_W:0] l_plus;

  assign l_plus = {1'b0, exp_q[FRAC_W], frac_q[FRAC_W]} + (CODE_W+1)'(1);
  assign code_o = small_q[FRAC_W] ? '0 : l_plus[CODE_W:1];

endmodule

`default_nettype wire

/* rtl/haptic_rumble_frame_encoder.sv */
// haptic_rumble_frame_encoder: top level, one 4-byte rumble half-frame per command
// depends on hrfe_pkg and hrfe_freq_log
`default_nettype none

// Takes one command every clock cycle: busy_o stays low, so a command is
// accepted whenever start_i is high. Each command yields exactly one
// half-frame on byte_*_o, marked by a one-cycle done_o pulse. Between the
// accepting edge and that pulse lie the input register (loaded at that edge),
// the two parallel eight-stage frequency log pipelines, each with six squaring
// multipliers, and the result register. Results come out in command order
// and cannot be held off by the receiver.
// amp_full_scale_i is written when amp_full_scale_we_i is high and should
// only change while no command is in flight.

module haptic_rumble_frame_encoder import hrfe_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              kind_i,
  input  wire logic [FREQ_W-1:0] high_freq_i,
  input  wire logic [FREQ_W-1:0] low_freq_i,
  input  wire logic [AMP_W-1:0]  high_amp_i,
  input  wire logic [AMP_W-1:0]  low_amp_i,
  input  wire logic              amp_full_scale_we_i,
  input  wire logic [FS_W-1:0]   amp_full_scale_i,
  output logic                   done_o,
  output logic      [BYTE_W-1:0] byte_zero_o,
  output logic      [BYTE_W-1:0] byte_one_o,
  output logic      [BYTE_W-1:0] byte_two_o,
  output logic      [BYTE_W-1:0] byte_three_o
);

  // fully pipelined, never stalls
  assign busy_o = 1'b0;

  // full-scale register
  logic [FS_W-1:0] fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FS_RESET;
    end else if (amp_full_scale_we_i) begin
      fs_q <= amp_full_scale_i;
    end
  end

  // input register
  logic              in_vld_q;
  kind_e             kind_q;
  logic [FREQ_W-1:0] hfreq_q;
  logic [FREQ_W-1:0] lfreq_q;
  logic [AMP_W-1:0]  hamp_q;
  logic [AMP_W-1:0]  lamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      kind_q  <= kind_e'(kind_i);
      hfreq_q <= high_freq_i;
      lfreq_q <= low_freq_i;
      hamp_q  <= high_amp_i;
      lamp_q  <= low_amp_i;
    end
  end

  // amplitude codes: saturate at 1.0, scale, truncate
  logic [AMP_W-1:0]      hamp_sat;
  logic [AMP_W-1:0]      lamp_sat;
  logic [FS_W+AMP_W-1:0] hamp_prod;
  logic [FS_W+AMP_W-1:0] lamp_prod;

  assign hamp_sat  = (hamp_q > AMP_ONE) ? AMP_ONE : hamp_q;
  assign lamp_sat  = (lamp_q > AMP_ONE) ? AMP_ONE : lamp_q;
  assign hamp_prod = fs_q * hamp_sat;
  assign lamp_prod = fs_q * lamp_sat;

  // frequency log units
  logic [CODE_W-1:0] hcode;
  logic [CODE_W-1:0] lcode;

  hrfe_freq_log u_high_log (
    .clk_i  (clk_i),
    .freq_i (hfreq_q),
    .code_o (hcode)
  );

  hrfe_freq_log u_low_log (
    .clk_i  (clk_i),
    .freq_i (lfreq_q),
    .code_o (lcode)
  );

  // delay line for valid, kind and amplitude codes, aligned with the log units
  logic              dly_vld_q  [FREQ_LAT];
  kind_e             dly_kind_q [FREQ_LAT];
  logic [BYTE_W-1:0] dly_ha_q   [FREQ_LAT];
  logic [BYTE_W-1:0] dly_la_q   [FREQ_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FREQ_LAT; i++) begin
        dly_vld_q[i] <= 1'b0;
      end
    end else begin
      dly_vld_q[0] <= in_vld_q;
      for (int i = 1; i < FREQ_LAT; i++) begin
        dly_vld_q[i] <= dly_vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dly_kind_q[0] <= kind_q;
    dly_ha_q[0]   <= hamp_prod[16 +: BYTE_W];
    dly_la_q[0]   <= lamp_prod[16 +: BYTE_W];
    for (int i = 1; i < FREQ_LAT; i++) begin
      dly_kind_q[i] <= dly_kind_q[i-1];
      dly_ha_q[i]   <= dly_ha_q[i-1];
      dly_la_q[i]   <= dly_la_q[i-1];
    end
  end

  // clamp codes to their bands and pack the half-frame
  logic [CODE_W-1:0] hcode_clamp;
  logic [CODE_W-1:0] lcode_clamp;
  logic [6:0]        hfield;
  logic [6:0]        lfield;
  logic [BYTE_W-1:0] ha_cur;
  logic [BYTE_W-1:0] la_cur;
  logic [BYTE_W-1:0] byte_zero_d;
  logic [BYTE_W-1:0] byte_one_d;
  logic [BYTE_W-1:0] byte_two_d;
  logic [BYTE_W-1:0] byte_three_d;

  assign hcode_clamp = (hcode < HI_CODE_MIN) ? HI_CODE_MIN :
                       (hcode > HI_CODE_MAX) ? HI_CODE_MAX : hcode;
  assign lcode_clamp = (lcode < LO_CODE_MIN) ? LO_CODE_MIN :
                       (lcode > LO_CODE_MAX) ? LO_CODE_MAX : lcode;
  assign hfield      = 7'(hcode_clamp - HI_CODE_BASE);
  assign lfield      = 7'(lcode_clamp - LO_CODE_BASE);
  assign ha_cur      = dly_ha_q[FREQ_LAT-1];
  assign la_cur      = dly_la_q[FREQ_LAT-1];

  always_comb begin
    case (dly_kind_q[FREQ_LAT-1])
      KIND_STOP: begin
        byte_zero_d  = STOP_BYTE0;
        byte_one_d   = STOP_BYTE1;
        byte_two_d   = STOP_BYTE2;
        byte_three_d = STOP_BYTE3;
      end
      default: begin
        byte_zero_d  = {hfield[5:0], 2'b00};
        byte_one_d   = ha_cur + BYTE_W'(hfield[6]);
        byte_two_d   = {la_cur[0], lfield};
        byte_three_d = {1'b0, la_cur[BYTE_W-1:1]};
      end
    endcase
  end

  // result register
  logic              done_q;
  logic [BYTE_W-1:0] byte_zero_q;
  logic [BYTE_W-1:0] byte_one_q;
  logic [BYTE_W-1:0] byte_two_q;
  logic [BYTE_W-1:0] byte_three_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dly_vld_q[FREQ_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dly_vld_q[FREQ_LAT-1]) begin
      byte_zero_q  <= byte_zero_d;
      byte_one_q   <= byte_one_d;
      byte_two_q   <= byte_two_d;
      byte_three_q <= byte_three_d;
    end
  end

  assign done_o       = done_q;
  assign byte_zero_o  = byte_zero_q;
  assign byte_one_o   = byte_one_q;
  assign byte_two_o   = byte_two_q;
  assign byte_three_o = byte_three_q;

endmodule

`default_nettype wire

/* tb/hrfe_frame_checker.sv */
// hrfe_frame_checker: watches the command and half-frame ports of the rumble encoder,
// predicts each half-frame and compares it with what comes out
// depends on hrfe_pkg
module hrfe_frame_checker import hrfe_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_o,
  input  wire logic              kind_i,
  input  wire logic [FREQ_W-1:0] high_freq_i,
  input  wire logic [FREQ_W-1:0] low_freq_i,
  input  wire logic [AMP_W-1:0]  high_amp_i,
  input  wire logic [AMP_W-1:0]  low_amp_i,
  input  wire logic              amp_full_scale_we_i,
  input  wire logic [FS_W-1:0]   amp_full_scale_i,
  input  wire logic              done_o,
  input  wire logic [BYTE_W-1:0] byte_zero_o,
  input  wire logic [BYTE_W-1:0] byte_one_o,
  input  wire logic [BYTE_W-1:0] byte_two_o,
  input  wire logic [BYTE_W-1:0] byte_three_o,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } frame_t;

  frame_t            frame_q[$];
  frame_t            want;
  frame_t            got;
  logic [FS_W-1:0]   full_scale;
  int                mismatch_cnt;

  // round(32*log2(f/10)) in fixed point, clamped to the band
  function automatic logic [31:0] band_code(logic [FREQ_W-1:0] f, logic [31:0] lo,
                                            logic [31:0] hi);
    logic [63:0] n;
    logic [63:0] m;
    logic [31:0] e;
    logic [31:0] l;
    logic [31:0] w;
    logic [31:0] code;
    n = ({48'd0, f} << (30 - FREQ_FRAC_BITS)) / 64'd10;
    code = 0;
    if (n >= (64'd1 << 30)) begin
      e = 0;
      while ((n >> e) >= (64'd1 << 31)) e++;
      m = n >> e;
      l = e * 64;
      // six squarings give six fraction bits of 64*log2
      for (w = 32; w != 0; w = w >> 1) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          l = l + w;
          m = m >> 1;
        end
      end
      code = (l + 1) >> 1;
    end
    if (code < lo) code = lo;
    if (code > hi) code = hi;
    return code;
  endfunction

  // saturate at 1.0 and scale by the full-scale code, truncating
  function automatic logic [7:0] amp_level(logic [AMP_W-1:0] a, logic [FS_W-1:0] fs);
    logic [AMP_W-1:0] sat;
    logic [24:0]      prod;
    sat = (a > AMP_ONE) ? AMP_ONE : a;
    prod = fs * sat;
    return prod[23:16];
  endfunction

  function automatic frame_t predict_frame(logic kind, logic [FREQ_W-1:0] hfreq,
                                           logic [FREQ_W-1:0] lfreq, logic [AMP_W-1:0] hamp,
                                           logic [AMP_W-1:0] lamp, logic [FS_W-1:0] fs);
    frame_t      f;
    logic [31:0] hfield;
    logic [31:0] lfield;
    logic [7:0]  ha;
    logic [7:0]  la;
    if (kind == KIND_STOP) begin
      f.b0 = STOP_BYTE0;
      f.b1 = STOP_BYTE1;
      f.b2 = STOP_BYTE2;
      f.b3 = STOP_BYTE3;
      return f;
    end
    hfield = (band_code(hfreq, HI_CODE_MIN, HI_CODE_MAX) - HI_CODE_BASE) * 4;
    lfield = band_code(lfreq, LO_CODE_MIN, LO_CODE_MAX) - LO_CODE_BASE;
    ha = amp_level(hamp, fs);
    la = amp_level(lamp, fs);
    f.b0 = hfield[7:0];
    f.b1 = ha + hfield[15:8];
    f.b2 = lfield[7:0] + {la[0], 7'd0};
    f.b3 = {1'b0, la[7:1]};
    return f;
  endfunction

  // track the register, predict accepted commands, compare half-frames
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q.delete();
      full_scale <= FS_RESET;
      mismatch_cnt = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (done_o) begin
        got = '{byte_zero_o, byte_one_o, byte_two_o, byte_three_o};
        if (frame_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected half-frame %h %h %h %h", got.b0, got.b1, got.b2, got.b3);
        end else begin
          want = frame_q.pop_front();
          if (got.b0 !== want.b0 || got.b1 !== want.b1 || got.b2 !== want.b2 ||
              got.b3 !== want.b3) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("half-frame mismatch: expected %h %h %h %h, got %h %h %h %h",
                       want.b0, want.b1, want.b2, want.b3, got.b0, got.b1, got.b2, got.b3);
          end
        end
      end
      if (start_i && busy_o === 1'b0)
        frame_q.push_back(predict_frame(kind_i, high_freq_i, low_freq_i, high_amp_i,
                                        low_amp_i, full_scale));
      if (amp_full_scale_we_i)
        full_scale <= amp_full_scale_i;
      fail_count_o <= mismatch_cnt;
      pending_o <= frame_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// tb_top: stimulus and verdict for the rumble half-frame encoder
// depends on hrfe_pkg, haptic_rumble_frame_encoder and hrfe_frame_checker
module tb_top import hrfe_pkg::*; ();

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              kind_i = KIND_PLAY;
  logic [FREQ_W-1:0] high_freq_i = '0;
  logic [FREQ_W-1:0] low_freq_i = '0;
  logic [AMP_W-1:0]  high_amp_i = '0;
  logic [AMP_W-1:0]  low_amp_i = '0;
  logic              amp_full_scale_we_i = 1'b0;
  logic [FS_W-1:0]   amp_full_scale_i = '0;
  logic              done_o;
  logic [BYTE_W-1:0] byte_zero_o;
  logic [BYTE_W-1:0] byte_one_o;
  logic [BYTE_W-1:0] byte_two_o;
  logic [BYTE_W-1:0] byte_three_o;
  int                fail_count;
  int                pending;

  localparam int SETTLE_CYCLES = FREQ_LAT + 6;

  always #6 clk_i = ~clk_i;

  haptic_rumble_frame_encoder i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .kind_i             (kind_i),
    .high_freq_i        (high_freq_i),
    .low_freq_i         (low_freq_i),
    .high_amp_i         (high_amp_i),
    .low_amp_i          (low_amp_i),
    .amp_full_scale_we_i(amp_full_scale_we_i),
    .amp_full_scale_i   (amp_full_scale_i),
    .done_o             (done_o),
    .byte_zero_o        (byte_zero_o),
    .byte_one_o         (byte_one_o),
    .byte_two_o         (byte_two_o),
    .byte_three_o       (byte_three_o)
  );

  hrfe_frame_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .kind_i             (kind_i),
    .high_freq_i        (high_freq_i),
    .low_freq_i         (low_freq_i),
    .high_amp_i         (high_amp_i),
    .low_amp_i          (low_amp_i),
    .amp_full_scale_we_i(amp_full_scale_we_i),
    .amp_full_scale_i   (amp_full_scale_i),
    .done_o             (done_o),
    .byte_zero_o        (byte_zero_o),
    .byte_one_o         (byte_one_o),
    .byte_two_o         (byte_two_o),
    .byte_three_o       (byte_three_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // one command transaction, entered and left at a falling edge
  task automatic send_cmd(logic kind, logic [FREQ_W-1:0] hf, logic [FREQ_W-1:0] lf,
                          logic [AMP_W-1:0] ha, logic [AMP_W-1:0] la);
    start_i <= 1'b1;
    kind_i <= kind;
    high_freq_i <= hf;
    low_freq_i <= lf;
    high_amp_i <= ha;
    low_amp_i <= la;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
  endtask

  // let every half-frame in flight come out, then a few quiet cycles
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_full_scale(logic [FS_W-1:0] value);
    amp_full_scale_we_i <= 1'b1;
    amp_full_scale_i <= value;
    @(posedge clk_i);
    @(negedge clk_i);
    amp_full_scale_we_i <= 1'b0;
  endtask

  // frequency mix: full range, each band with its edges, and near zero
  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 3))
      0:       return FREQ_W'($urandom);
      1:       return FREQ_W'($urandom_range(1200, 21000));
      2:       return FREQ_W'($urandom_range(600, 10500));
      default: return FREQ_W'($urandom_range(0, 200));
    endcase
  endfunction

  // amplitude mix: full range, 0 to 1.0, around 1.0, and exactly 0 or 1.0
  function automatic logic [AMP_W-1:0] pick_amp();
    case ($urandom_range(0, 4))
      0:       return AMP_W'($urandom);
      1:       return AMP_W'($urandom_range(0, 65536));
      2:       return AMP_W'($urandom_range(65530, 65542));
      3:       return ($urandom_range(0, 1) != 0) ? AMP_ONE : '0;
      default: return AMP_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // random commands in bursts, gaps of random length between them
  task automatic run_random(int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_cmd(($urandom_range(0, 6) == 0) ? KIND_STOP : KIND_PLAY, pick_freq(),
                 pick_freq(), pick_amp(), pick_amp());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start_i <= 1'b0;
        high_freq_i <= FREQ_W'($urandom);
        low_amp_i <= AMP_W'($urandom);
        repeat (gap) @(negedge clk_i);
      end
    end
    start_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // run limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [FS_W-1:0] scales[6];
    scales = '{8'd0, 8'd1, FS_W'($urandom_range(2, 254)), 8'd128, 8'd255, FS_RESET};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed commands at the reset full scale
    send_cmd(KIND_STOP, 16'hffff, 16'hffff, 17'h1ffff, 17'h1ffff);
    send_cmd(KIND_STOP, 16'h0000, 16'h0000, 17'h00000, 17'h00000);
    send_cmd(KIND_PLAY, 16'h0000, 16'h0000, 17'h00000, 17'h00000);
    send_cmd(KIND_PLAY, 16'hffff, 16'hffff, 17'h1ffff, 17'h1ffff);
    send_cmd(KIND_PLAY, 16'd159, 16'd159, 17'h10000, 17'h10000);
    send_cmd(KIND_PLAY, 16'd160, 16'd160, 17'h0ffff, 17'h10001);
    send_cmd(KIND_PLAY, 16'd1308, 16'd654, 17'h0ffff, 17'h0ffff);
    send_cmd(KIND_PLAY, 16'd1307, 16'd653, 17'h00001, 17'h00001);
    send_cmd(KIND_PLAY, 16'd20041, 16'd10021, 17'h10001, 17'h08000);
    send_cmd(KIND_PLAY, 16'd20042, 16'd10022, 17'h08000, 17'h10001);
    send_cmd(KIND_PLAY, 16'd5120, 16'd2560, 17'h00147, 17'h00148);
    send_cmd(KIND_PLAY, 16'd16000, 16'd1600, 17'h1ffff, 17'h00000);
    send_cmd(KIND_PLAY, 16'h5555, 16'haaaa, 17'h15555, 17'h0aaaa);
    send_cmd(KIND_PLAY, 16'haaaa, 16'h5555, 17'h0aaaa, 17'h15555);
    start_i <= 1'b0;
    @(negedge clk_i);

    // full scale 255: amplitude byte wraps when the frequency carry is set
    drain();
    write_full_scale(8'd255);
    send_cmd(KIND_PLAY, 16'hffff, 16'd160, 17'h10000, 17'h10000);
    send_cmd(KIND_PLAY, 16'd5120, 16'd160, 17'h1ffff, 17'h0ffff);
    send_cmd(KIND_PLAY, 16'd5100, 16'd10021, 17'h10000, 17'h0ff00);
    send_cmd(KIND_STOP, 16'd5120, 16'd160, 17'h10000, 17'h10000);
    start_i <= 1'b0;
    @(negedge clk_i);
    run_random(240);

    // random phases over further full-scale settings
    foreach (scales[p]) begin
      drain();
      write_full_scale(scales[p]);
      run_random(200);
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hrfe_pkg.sv
rtl/hrfe_freq_log.sv
rtl/haptic_rumble_frame_encoder.sv
tb/hrfe_frame_checker.sv
tb/tb_top.sv
